>>> src/dccm_pkg.sv
// package for the duty cycle capture meter
// holds the transfer structs, field widths and shared constants; no dependencies
package dccm_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int TIME_FIELD_BITS    = 16;
  localparam int PCT_BITS           = 7;
  localparam int CNT_BITS           = $clog2(PCT_BITS);

  localparam logic [PCT_BITS-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_BITS-1:0] PCT_ZERO  = 7'd0;

  typedef struct packed {
    logic                       rising_edge;
    logic [TIME_FIELD_BITS-1:0] capture_time;
  } capture_t;

  typedef struct packed {
    logic [PCT_BITS-1:0]        percent_high;
    logic [TIME_FIELD_BITS-1:0] period_ticks;
    logic [TIME_FIELD_BITS-1:0] high_ticks;
    logic [TIME_FIELD_BITS-1:0] events_seen;
    logic                       zero_period;
  } result_t;

endpackage

>>> src/dccm_sub_unit.sv
// shared subtract and compare unit of the duty cycle capture meter
// no package dependencies; width set by the instantiating module
module dccm_sub_unit #(
  parameter int WIDTH = 17
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  logic [WIDTH:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[WIDTH-1:0];
  assign borrow = full[WIDTH];

endmodule

>>> src/duty_cycle_capture_meter_unit.sv
// duty cycle capture meter, top level
// depends on dccm_pkg and dccm_sub_unit
// rising edges and opening falls are accepted back to back.
// a closing fall runs two subtracts, a compare and, unless the period is zero or
// the high time saturates, 7 restoring divide steps, all on the one shared subtractor,
// with a shift-add multiply by 100 before the divide; capture is stalled meanwhile.
// synchronous reset clears the control state and edge times; the result holds while stalled.
module duty_cycle_capture_meter_unit #(
  parameter int TIMER_BITS = dccm_pkg::TIMER_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               capture_valid,
  output logic               capture_stall,
  input  dccm_pkg::capture_t capture,
  output logic               result_valid,
  input  logic               result_stall,
  output dccm_pkg::result_t  result
);

  localparam int W  = TIMER_BITS;
  localparam int PB = dccm_pkg::PCT_BITS;
  localparam int NW = W + PB;
  localparam int FB = dccm_pkg::TIME_FIELD_BITS;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PER  = 7'b0000010,
    ST_HIGH = 7'b0000100,
    ST_CMP  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t                        state;
  logic [W-1:0]                  first_fall_time;
  logic                          first_fall_valid;
  logic [W-1:0]                  rise_time;
  logic [W-1:0]                  fall_time;
  logic [W-1:0]                  period;
  logic [W-1:0]                  high;
  logic [W-1:0]                  rem;
  logic [PB-1:0]                 num_low;
  logic [PB-1:0]                 pct;
  logic [PB-1:0]                 last_percent;
  logic [dccm_pkg::CNT_BITS-1:0] cnt;
  logic                          zero;
  logic [FB-1:0]                 event_count;

  logic         accept;
  logic [W-1:0] t_in;
  logic [W:0]   sub_a;
  logic [W:0]   sub_b;
  logic [W:0]   sub_diff;
  logic         sub_borrow;
  logic [W:0]   trial;
  logic [NW-1:0] prod;
  logic [NW-1:0] high_ext;
  logic         emit;
  logic         out_free;
  logic         load;

  assign capture_stall = (state != ST_IDLE);
  assign accept        = capture_valid && !capture_stall;
  assign t_in          = W'(capture.capture_time);
  assign trial         = {rem, num_low[PB-1]};
  assign high_ext      = NW'(high);
  assign prod          = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);
  assign emit          = zero || (pct != last_percent);
  assign out_free      = !result_valid || !result_stall;
  assign load          = (state == ST_DONE) && emit && out_free;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state)
      ST_PER: begin
        sub_a = {1'b0, fall_time};
        sub_b = {1'b0, first_fall_time};
      end
      ST_HIGH: begin
        sub_a = {1'b0, fall_time};
        sub_b = {1'b0, rise_time};
      end
      ST_CMP: begin
        sub_a = {1'b0, high};
        sub_b = {1'b0, period};
      end
      ST_DIV: begin
        sub_a = trial;
        sub_b = {1'b0, period};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  dccm_sub_unit #(
    .WIDTH(W + 1)
  ) u_sub (
    .a     (sub_a),
    .b     (sub_b),
    .diff  (sub_diff),
    .borrow(sub_borrow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      first_fall_time  <= '0;
      first_fall_valid <= 1'b0;
      rise_time        <= '0;
      last_percent     <= '0;
      event_count      <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            event_count <= event_count + 1'b1;
            if (capture.rising_edge) begin
              rise_time <= t_in;
            end else if (!first_fall_valid) begin
              first_fall_time  <= t_in;
              first_fall_valid <= 1'b1;
            end else begin
              fall_time        <= t_in;
              first_fall_valid <= 1'b0;
              state            <= ST_PER;
            end
          end
        end
        ST_PER: begin
          period <= sub_diff[W-1:0];
          state  <= ST_HIGH;
        end
        ST_HIGH: begin
          high  <= sub_diff[W-1:0];
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (period == '0) begin
            pct   <= dccm_pkg::PCT_ZERO;
            zero  <= 1'b1;
            state <= ST_DONE;
          end else if (!sub_borrow) begin
            pct   <= dccm_pkg::PCT_SCALE;
            zero  <= 1'b0;
            state <= ST_DONE;
          end else begin
            zero  <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem     <= prod[NW-1:PB];
          num_low <= prod[PB-1:0];
          pct     <= dccm_pkg::PCT_ZERO;
          cnt     <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (!sub_borrow) begin
            rem <= sub_diff[W-1:0];
          end else begin
            rem <= trial[W-1:0];
          end
          pct     <= {pct[PB-2:0], !sub_borrow};
          num_low <= {num_low[PB-2:0], 1'b0};
          cnt     <= cnt + 1'b1;
          if (cnt == dccm_pkg::CNT_BITS'(PB - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!emit) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            result_valid        <= 1'b1;
            result.percent_high <= pct;
            result.period_ticks <= FB'(period);
            result.high_ticks   <= FB'(high);
            result.events_seen  <= event_count;
            result.zero_period  <= zero;
            last_percent        <= pct;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.percent_high <= dccm_pkg::PCT_SCALE))
    else $error("percent above full scale");

  a_zero_pct: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.zero_period) |-> (result.percent_high == dccm_pkg::PCT_ZERO))
    else $error("zero period with nonzero percent");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < period))
    else $error("divider remainder not below period");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result loaded outside the done step");

endmodule

>>> sim/dccm_meter_checker.sv
`timescale 1ns / 100ps
// duty cycle meter checker: predicts readings from accepted capture transfers
// and compares them field by field with accepted result transfers; uses dccm_pkg
module dccm_meter_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               capture_valid,
  input  logic               capture_stall,
  input  dccm_pkg::capture_t capture,
  input  logic               result_valid,
  input  logic               result_stall,
  input  dccm_pkg::result_t  result,
  output int                 errors,
  output int                 pending,
  output int                 readings_checked,
  output int                 zero_readings
);

  logic [dccm_pkg::TIME_FIELD_BITS-1:0] fall_stamp;
  logic                                 fall_open;
  logic [dccm_pkg::TIME_FIELD_BITS-1:0] rise_stamp;
  logic [dccm_pkg::PCT_BITS-1:0]        last_pct;
  logic [dccm_pkg::TIME_FIELD_BITS-1:0] edge_count;

  dccm_pkg::result_t expected_readings[$];
  dccm_pkg::result_t want;
  int      mismatch_count   = 0;
  int      waiting          = 0;
  int      checked_count    = 0;
  int      zero_count       = 0;

  assign errors           = mismatch_count;
  assign pending          = waiting;
  assign readings_checked = checked_count;
  assign zero_readings    = zero_count;

  function automatic void predict_duty(dccm_pkg::capture_t c);
    logic [dccm_pkg::TIME_FIELD_BITS-1:0] per;
    logic [dccm_pkg::TIME_FIELD_BITS-1:0] hi;
    int unsigned                          q;
    logic [dccm_pkg::PCT_BITS-1:0]        pct;
    logic                                 zero;
    dccm_pkg::result_t                    r;
    edge_count = edge_count + 1'b1;
    if (c.rising_edge) begin
      rise_stamp = c.capture_time;
      return;
    end
    if (!fall_open) begin
      fall_stamp = c.capture_time;
      fall_open  = 1'b1;
      return;
    end
    per       = c.capture_time - fall_stamp;
    hi        = c.capture_time - rise_stamp;
    fall_open = 1'b0;
    zero      = (per == '0);
    if (zero) begin
      pct = dccm_pkg::PCT_ZERO;
    end else begin
      q   = (32'(hi) * 32'(dccm_pkg::PCT_SCALE)) / 32'(per);
      pct = (q > 32'(dccm_pkg::PCT_SCALE)) ? dccm_pkg::PCT_SCALE
                                            : q[dccm_pkg::PCT_BITS-1:0];
    end
    // unchanged percentage drops the period silently
    if (!zero && pct == last_pct) return;
    last_pct       = pct;
    r.percent_high = pct;
    r.period_ticks = per;
    r.high_ticks   = hi;
    r.events_seen  = edge_count;
    r.zero_period  = zero;
    expected_readings.push_back(r);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fall_stamp = '0;
      fall_open  = 1'b0;
      rise_stamp = '0;
      last_pct   = '0;
      edge_count = '0;
      expected_readings.delete();
    end else begin
      if (capture_valid && !capture_stall) predict_duty(capture);
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual pct %0d period %0d high %0d",
                   $time, result.percent_high, result.period_ticks, result.high_ticks);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("percent_high", want.percent_high, result.percent_high);
          check_field("period_ticks", want.period_ticks, result.period_ticks);
          check_field("high_ticks", want.high_ticks, result.high_ticks);
          check_field("events_seen", want.events_seen, result.events_seen);
          check_field("zero_period", want.zero_period, result.zero_period);
          checked_count++;
          if (want.zero_period) zero_count++;
        end
      end
    end
    waiting = expected_readings.size();
  end

endmodule

>>> sim/tb_duty_cycle_capture_meter_unit.sv
`timescale 1ns / 100ps
// testbench top for duty_cycle_capture_meter_unit: drives capture edges in bursts,
// stalls the result side and gives the verdict; uses dccm_pkg and dccm_meter_checker
module tb_duty_cycle_capture_meter_unit;

  localparam int RANDOM_EDGES = 850;

  logic               clk;
  logic               rst           = 1'b1;
  logic               capture_valid = 1'b0;
  logic               capture_stall;
  dccm_pkg::capture_t capture       = '0;
  logic               result_valid;
  logic               result_stall  = 1'b0;
  dccm_pkg::result_t  result;

  int errors;
  int pending;
  int readings_checked;
  int zero_readings;

  int         sent       = 0;
  int         burst_left = 0;
  logic       fall_open  = 1'b0;
  logic [9:0] stall_phase = '0;
  logic [dccm_pkg::TIME_FIELD_BITS-1:0] last_period = 16'd100;
  logic [dccm_pkg::TIME_FIELD_BITS-1:0] last_high   = 16'd50;

  duty_cycle_capture_meter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .capture_valid (capture_valid),
    .capture_stall (capture_stall),
    .capture       (capture),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  dccm_meter_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .capture_valid    (capture_valid),
    .capture_stall    (capture_stall),
    .capture          (capture),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .errors           (errors),
    .pending          (pending),
    .readings_checked (readings_checked),
    .zero_readings    (zero_readings)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall: quiet, sparse random, long regular runs, dense random
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0: result_stall <= 1'b0;
      2'd1: result_stall <= ($urandom_range(0, 3) == 0);
      2'd2: result_stall <= (stall_phase[4:0] < 5'd15);
      default: result_stall <= $urandom_range(0, 1);
    endcase
  end

  task automatic send_edge(logic rising, logic [dccm_pkg::TIME_FIELD_BITS-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        @(negedge clk);
        capture_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    capture_valid <= 1'b1;
    capture       <= '{rising_edge: rising, capture_time: stamp};
    do @(posedge clk); while (capture_stall);
    sent++;
    if (!rising) fall_open = !fall_open;
  endtask

  task automatic send_period(logic [dccm_pkg::TIME_FIELD_BITS-1:0] t0,
                             logic [dccm_pkg::TIME_FIELD_BITS-1:0] per,
                             logic [dccm_pkg::TIME_FIELD_BITS-1:0] hi);
    if (fall_open) send_edge(1'b0, 16'($urandom()));
    send_edge(1'b0, t0);
    send_edge(1'b1, t0 + per - hi);
    send_edge(1'b0, t0 + per);
    last_period = per;
    last_high   = hi;
  endtask

  initial begin
    int                                   kind;
    logic [dccm_pkg::TIME_FIELD_BITS-1:0] per;
    logic [dccm_pkg::TIME_FIELD_BITS-1:0] hi;
    logic [dccm_pkg::TIME_FIELD_BITS-1:0] stamp;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero period before any rise
    send_edge(1'b0, 16'h0000);
    send_edge(1'b0, 16'h0000);
    // no rise since reset, high time exceeds the period and saturates
    send_edge(1'b0, 16'd100);
    send_edge(1'b0, 16'd200);
    send_period(16'd1000, 16'd100, 16'd50);
    // wraparound of the timer
    send_period(16'hfff0, 16'h0020, 16'h0011);
    // longest period
    send_period(16'h0000, 16'hffff, 16'h8000);
    // zero period after rises covering every bit
    send_edge(1'b1, 16'haaaa);
    send_edge(1'b1, 16'h5555);
    send_edge(1'b0, 16'hffff);
    send_edge(1'b0, 16'hffff);
    // zero percent after a zero period leaves the reading unchanged
    send_period(16'h0000, 16'd1, 16'd0);
    // exactly full duty
    send_period(16'd10, 16'd10, 16'd10);

    while (sent < RANDOM_EDGES + 23) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        per = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 400));
        hi  = 16'($urandom_range(0, per));
        send_period(16'($urandom()), per, hi);
      end else if (kind < 68) begin
        send_period(16'($urandom()), last_period, last_high);
      end else if (kind < 74) begin
        if (fall_open) send_edge(1'b0, 16'($urandom()));
        stamp = 16'($urandom());
        send_edge(1'b0, stamp);
        send_edge(1'b0, stamp);
      end else if (kind < 85) begin
        // stale rise: rise lands before the opening fall
        stamp = 16'($urandom());
        send_edge(1'b1, stamp);
        send_edge(1'b0, stamp + 16'($urandom_range(0, 300)));
        send_edge(1'b0, stamp + 16'($urandom_range(0, 600)));
      end else begin
        send_edge(1'($urandom_range(0, 1)), 16'($urandom()));
      end
    end

    @(negedge clk);
    capture_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d capture transfers; checked %0d readings, %0d of them zero period",
             sent, readings_checked, zero_readings);
    if (errors == 0 && pending == 0) begin
      $display("duty_cycle_capture_meter_unit test passed");
    end else begin
      $display("duty_cycle_capture_meter_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("duty_cycle_capture_meter_unit test failed");
    $finish;
  end

endmodule
